/* rtl/spsm_pkg.sv */
// shared types and constants for the planar shadow matrix flatten block
// no dependencies; imported by every module of the block
`default_nettype none

package spsm_pkg;

  localparam int WORD_W    = 32;
  localparam int ELEM_W    = 16;
  localparam int SUM_W     = 18;
  localparam int COL_W     = 2;
  localparam int FRAC_BITS = 12;

  localparam logic [FRAC_BITS-1:0] ROUND_ADD = 12'hfff;
  localparam logic [COL_W-1:0]     TRANS_COL = 2'd3;

  // handshake status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } spsm_status_t;

endpackage

`default_nettype wire

/* rtl/spsm_div.sv */
// radix-2 restoring signed divider, one quotient bit per cycle, truncating
// depends on spsm_pkg
`default_nettype none

module spsm_div (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire  signed [spsm_pkg::WORD_W-1:0]  num,
  input  wire  signed [spsm_pkg::SUM_W-1:0]   den,
  output logic signed [spsm_pkg::WORD_W-1:0]  quo,
  output spsm_pkg::spsm_status_t              status
);
  import spsm_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] dabs;
  logic [WORD_W-1:0] dq;
  logic             neg;

  logic [SUM_W:0]   rem_sh;
  logic [SUM_W+1:0] diff;
  logic             ge;
  logic [WORD_W-1:0] dq_next;

  always_comb begin
    rem_sh  = {rem, dq[WORD_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dabs};
    ge      = ~diff[SUM_W+1];
    dq_next = {dq[WORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        dq    <= num[WORD_W-1] ? WORD_W'(-num) : num;
        dabs  <= den[SUM_W-1] ? SUM_W'(-den) : den;
        neg   <= num[WORD_W-1] ^ den[SUM_W-1];
      end else if (busy) begin
        rem   <= ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        dq    <= dq_next;
        count <= count + 1'b1;
        if (count == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -dq_next : dq_next;
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

`default_nettype wire

/* rtl/spsm_mul.sv */
// bit-serial dual shift-add multiplier, wraps at 32 bits, then scales by 2^-12
// rounding toward zero; depends on spsm_pkg
`default_nettype none

module spsm_mul (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire  signed [spsm_pkg::WORD_W-1:0]  q,
  input  wire  signed [spsm_pkg::SUM_W-1:0]   xa,
  input  wire  signed [spsm_pkg::SUM_W-1:0]   za,
  output logic signed [spsm_pkg::WORD_W-1:0]  sx,
  output logic signed [spsm_pkg::WORD_W-1:0]  sz,
  output spsm_pkg::spsm_status_t              status
);
  import spsm_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic              fin;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [WORD_W-1:0] qsh;
  logic [WORD_W-1:0] ma;
  logic [WORD_W-1:0] mb;
  logic [WORD_W-1:0] acca;
  logic [WORD_W-1:0] accb;

  logic [WORD_W-1:0] ra;
  logic [WORD_W-1:0] rb;

  // bias negative products so the arithmetic shift truncates toward zero
  always_comb begin
    ra = acca + (acca[WORD_W-1] ? {{(WORD_W-FRAC_BITS){1'b0}}, ROUND_ADD} : '0);
    rb = accb + (accb[WORD_W-1] ? {{(WORD_W-FRAC_BITS){1'b0}}, ROUND_ADD} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        qsh   <= q;
        ma    <= {{(WORD_W-SUM_W){xa[SUM_W-1]}}, xa};
        mb    <= {{(WORD_W-SUM_W){za[SUM_W-1]}}, za};
        acca  <= '0;
        accb  <= '0;
      end else if (busy) begin
        if (qsh[0]) begin
          acca <= acca + ma;
          accb <= accb + mb;
        end
        ma    <= {ma[WORD_W-2:0], 1'b0};
        mb    <= {mb[WORD_W-2:0], 1'b0};
        qsh   <= {1'b0, qsh[WORD_W-1:1]};
        count <= count + 1'b1;
        if (count == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        sx   <= {{FRAC_BITS{ra[WORD_W-1]}}, ra[WORD_W-1:FRAC_BITS]};
        sz   <= {{FRAC_BITS{rb[WORD_W-1]}}, rb[WORD_W-1:FRAC_BITS]};
      end
    end
  end

  assign status = '{busy: busy | fin, done: done};

endmodule

`default_nettype wire

/* rtl/planar_shadow_matrix_flatten.sv */
// top level of the planar shadow matrix flatten block: column store and sequencer
// depends on spsm_pkg, spsm_div, spsm_mul
//
//   channel  | wires                                         | word moves when
//   ---------+-----------------------------------------------+---------------------------
//   item     | item_valid item_stall col dir_r* tgt_r* height | item_valid && !item_stall
//   result   | result_valid result_stall out_col out_r* last  | result_valid && !result_stall
//
// a load word (col 0..2) writes one column store entry; a compute word (col 3) gives four result words
// with y negative each result word passes issue, a serial divide, a serial multiply and emit;
// with y not negative it passes only issue and emit
// item_stall is high in reset and from a compute word until its last result is registered
// a result word held by result_stall holds the sequencer at the next emit
// rst is synchronous; the column store has no reset and must be loaded before use
`default_nettype none

module planar_shadow_matrix_flatten (
  input  wire                                 clk,
  input  wire                                 rst,
  // item channel
  input  wire                                 item_valid,
  output logic                                item_stall,
  input  wire         [spsm_pkg::COL_W-1:0]   col,
  input  wire  signed [spsm_pkg::ELEM_W-1:0]  dir_r0,
  input  wire  signed [spsm_pkg::ELEM_W-1:0]  dir_r1,
  input  wire  signed [spsm_pkg::ELEM_W-1:0]  dir_r2,
  input  wire  signed [spsm_pkg::WORD_W-1:0]  tgt_r0,
  input  wire  signed [spsm_pkg::WORD_W-1:0]  tgt_r1,
  input  wire  signed [spsm_pkg::WORD_W-1:0]  tgt_r2,
  input  wire  signed [spsm_pkg::WORD_W-1:0]  height,
  // result channel
  output logic                                result_valid,
  input  wire                                 result_stall,
  output logic        [spsm_pkg::COL_W-1:0]   out_col,
  output logic signed [spsm_pkg::WORD_W-1:0]  out_r0,
  output logic signed [spsm_pkg::WORD_W-1:0]  out_r1,
  output logic signed [spsm_pkg::WORD_W-1:0]  out_r2,
  output logic                                last
);
  import spsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t state;

  // column store: direction sums and target rows, one entry per matrix column
  logic signed [SUM_W-1:0]  dsum [3];
  logic signed [ELEM_W-1:0] tc0  [3];
  logic signed [ELEM_W-1:0] tc1  [3];
  logic signed [ELEM_W-1:0] tc2  [3];

  // translation word captured with the compute word
  logic signed [WORD_W-1:0] t0;
  logic signed [WORD_W-1:0] t1;
  logic signed [WORD_W-1:0] t2;
  logic signed [WORD_W-1:0] h;

  logic [COL_W-1:0] k;

  logic                     item_acc;
  logic                     res_free;
  logic                     proj;
  logic [1:0]               kk;
  logic signed [SUM_W-1:0]  load_sum;
  logic signed [WORD_W-1:0] numer;
  logic signed [WORD_W-1:0] sx_use;
  logic signed [WORD_W-1:0] sz_use;
  logic signed [ELEM_W-1:0] e0;
  logic signed [ELEM_W-1:0] e2;

  logic                     div_start;
  logic signed [WORD_W-1:0] quo;
  spsm_status_t             div_st;
  logic                     mul_start;
  logic signed [WORD_W-1:0] sx;
  logic signed [WORD_W-1:0] sz;
  spsm_status_t             mul_st;

  // no word is taken while reset is held
  assign item_stall = rst || (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign res_free   = !result_valid || !result_stall;

  // projection happens only for a negative y sum
  assign proj = dsum[1][SUM_W-1];
  assign kk   = (k == TRANS_COL) ? 2'd0 : k;

  always_comb begin
    load_sum = {{2{dir_r0[ELEM_W-1]}}, dir_r0}
             + {{2{dir_r1[ELEM_W-1]}}, dir_r1}
             + {{2{dir_r2[ELEM_W-1]}}, dir_r2};
  end

  // numerator is the middle element (or height) shifted up by the fraction, wrapped
  always_comb begin
    if (k == TRANS_COL) begin
      numer = {h[WORD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    end else begin
      numer = {{(WORD_W-ELEM_W-FRAC_BITS){tc1[kk][ELEM_W-1]}}, tc1[kk], {FRAC_BITS{1'b0}}};
    end
  end

  assign sx_use = proj ? sx : '0;
  assign sz_use = proj ? sz : '0;

  // matrix elements wrap at 16 bits, so only the low half of the correction matters
  assign e0 = tc0[kk] - sx_use[ELEM_W-1:0];
  assign e2 = tc2[kk] - sz_use[ELEM_W-1:0];

  assign div_start = (state == ST_START) && proj;
  assign mul_start = (state == ST_DIV) && div_st.done;

  spsm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (numer),
    .den    (dsum[1]),
    .quo    (quo),
    .status (div_st)
  );

  spsm_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .q      (quo),
    .xa     (dsum[0]),
    .za     (dsum[2]),
    .sx     (sx),
    .sz     (sz),
    .status (mul_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      k            <= '0;
    end else begin
      // a taken result frees the output register unless a new one lands below
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_acc) begin
            if (col == TRANS_COL) begin
              t0    <= tgt_r0;
              t1    <= tgt_r1;
              t2    <= tgt_r2;
              h     <= height;
              k     <= '0;
              state <= ST_START;
            end else begin
              dsum[col] <= load_sum;
              tc0[col]  <= tgt_r0[ELEM_W-1:0];
              tc1[col]  <= tgt_r1[ELEM_W-1:0];
              tc2[col]  <= tgt_r2[ELEM_W-1:0];
            end
          end
        end
        ST_START: begin
          state <= proj ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_st.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (res_free) begin
            result_valid <= 1'b1;
            out_col      <= k;
            if (k == TRANS_COL) begin
              out_r0 <= t0 - sx_use;
              out_r1 <= t1 - h;
              out_r2 <= t2 - sz_use;
              last   <= 1'b1;
              state  <= ST_IDLE;
            end else begin
              out_r0 <= {{(WORD_W-ELEM_W){e0[ELEM_W-1]}}, e0};
              out_r1 <= '0;
              out_r2 <= {{(WORD_W-ELEM_W){e2[ELEM_W-1]}}, e2};
              last   <= 1'b0;
              k      <= k + 1'b1;
              state  <= ST_START;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/spsm_checker.sv */
// port-level checks for planar_shadow_matrix_flatten, with the bind that attaches them
// depends on spsm_pkg and the top level
`default_nettype none

module spsm_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 item_valid,
  input wire                                 item_stall,
  input wire         [spsm_pkg::COL_W-1:0]   col,
  input wire                                 result_valid,
  input wire                                 result_stall,
  input wire         [spsm_pkg::COL_W-1:0]   out_col,
  input wire  signed [spsm_pkg::WORD_W-1:0]  out_r0,
  input wire  signed [spsm_pkg::WORD_W-1:0]  out_r1,
  input wire  signed [spsm_pkg::WORD_W-1:0]  out_r2,
  input wire                                 last
);
  import spsm_pkg::*;

  // a stalled result word holds its column, last flag and outer rows
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_r0) && $stable(out_r2)
      && $stable(out_col) && $stable(last))
    else $error("stalled result word changed");

  // last only on the translation word
  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> out_col == TRANS_COL)
    else $error("last on a matrix column");

  // matrix columns carry a cleared middle row and sign-extended 16-bit elements
  a_mat: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_col != TRANS_COL |-> out_r1 == '0
      && out_r0[WORD_W-1:ELEM_W] == {(WORD_W-ELEM_W){out_r0[ELEM_W-1]}}
      && out_r2[WORD_W-1:ELEM_W] == {(WORD_W-ELEM_W){out_r2[ELEM_W-1]}})
    else $error("malformed matrix column word");

  // a compute word makes the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && col == TRANS_COL |=> item_stall)
    else $error("compute word did not stall the item side");

  // the translation word follows column two
  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && out_col == 2'd2 |=> !result_valid || out_col == TRANS_COL)
    else $error("result words out of order");

endmodule

bind planar_shadow_matrix_flatten spsm_checker u_spsm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .col          (col),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_col      (out_col),
  .out_r0       (out_r0),
  .out_r1       (out_r1),
  .out_r2       (out_r2),
  .last         (last)
);

`default_nettype wire
